### rtl/core/tsd_pkg.sv
// Shared types and constants for the tableau substitution decipher.
// No dependencies; every other file but tsd_ram takes its names from here.
`default_nettype none

package tsd_pkg;

	localparam int unsigned ALPHABET_SIZE_DEF = 94;
	localparam int unsigned KEY_LENGTH_DEF    = 54;

	// position + message_length needs one bit more than either
	localparam int unsigned SUM_W = 17;

	localparam logic [7:0] STORE_OFFSET = 8'h7f;
	localparam logic [7:0] CHAR_BASE    = 8'd33;

	typedef enum logic [1:0] {
		KIND_TABLEAU  = 2'd0,
		KIND_KEY      = 2'd1,
		KIND_DECIPHER = 2'd2
	} kind_t;

	typedef struct packed {
		logic       tab_load;
		logic       key_load;
		logic       decipher;
		logic [6:0] row;
		logic [6:0] column;
		logic [7:0] value;
		logic [7:0] cipher;
	} item_t;

	typedef struct packed {
		logic       wr;
		logic       rd;
		logic [6:0] row;
		logic [6:0] column;
		logic [7:0] value;
		logic [7:0] cipher;
	} tab_req_t;

endpackage

`default_nettype wire

### rtl/core/tsd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tsd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                           wdata,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

### rtl/core/tsd_key_index.sv
// Key index unit: (position + length) mod KEY_LENGTH over two register stages.
// Depends on tsd_pkg.
`default_nettype none

module tsd_key_index #(
	parameter int unsigned KEY_LENGTH = tsd_pkg::KEY_LENGTH_DEF
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               vld_i,
	input  wire tsd_pkg::item_t                                     item_i,
	input  wire logic [tsd_pkg::SUM_W-1:0]                          sum_i,
	output logic                                                    vld_o,
	output tsd_pkg::item_t                                          item_o,
	output logic [((KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1)-1:0] kidx_o
);

	localparam int unsigned SUM_W       = tsd_pkg::SUM_W;
	localparam int unsigned KIDX_W      = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
	localparam int unsigned RECIP_SHIFT = SUM_W + 8;
	localparam int unsigned PROD_W      = SUM_W + RECIP_SHIFT + 1;
	localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT+1)'((64'd1 << RECIP_SHIFT) / KEY_LENGTH);

	logic [PROD_W-1:0] prod;
	logic              vld_s2;
	tsd_pkg::item_t    item_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [SUM_W-1:0]  quot_s2;
	logic [SUM_W-1:0]  rem_raw;
	logic [SUM_W-1:0]  rem_fix;

	// quotient estimate, low by at most one
	assign prod = PROD_W'(sum_i) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_i;
		sum_s2  <= sum_i;
		quot_s2 <= prod[RECIP_SHIFT +: SUM_W];
	end

	always_comb begin
		rem_raw = sum_s2 - SUM_W'(quot_s2 * SUM_W'(KEY_LENGTH));
		rem_fix = (rem_raw >= SUM_W'(KEY_LENGTH)) ? rem_raw - SUM_W'(KEY_LENGTH) : rem_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_o <= item_s2;
		kidx_o <= KIDX_W'(rem_fix);
	end

endmodule

`default_nettype wire

### rtl/core/tsd_row_match.sv
// Tableau store as one RAM lane per column, row compare and first-match search.
// Depends on tsd_pkg and tsd_ram.
`default_nettype none

module tsd_row_match #(
	parameter int unsigned ALPHABET_SIZE = tsd_pkg::ALPHABET_SIZE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tsd_pkg::tab_req_t req_i,
	output logic                   hit_o,
	output logic [6:0]             plain_char_o
);

	localparam int unsigned ROW_W      = $clog2(ALPHABET_SIZE);
	localparam int unsigned GROUP_SIZE = 8;
	localparam int unsigned GROUPS     = (ALPHABET_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int unsigned LANES_PAD  = GROUPS * GROUP_SIZE;

	logic [ROW_W-1:0]     addr;
	logic [7:0]           lane_rd [ALPHABET_SIZE];
	logic                 look_s5;
	logic [7:0]           cipher_s5;
	logic [LANES_PAD-1:0] match;
	logic                 look_s6;
	logic [LANES_PAD-1:0] match_s6;
	logic [GROUPS-1:0]    grp_any;
	logic [2:0]           grp_idx [GROUPS];
	logic                 look_s7;
	logic [GROUPS-1:0]    grp_any_s7;
	logic [2:0]           grp_idx_s7 [GROUPS];
	logic                 found;
	logic [7:0]           col;
	logic                 hit_q;
	logic [6:0]           plain_q;

	assign addr = ROW_W'(req_i.row);

	for (genvar c = 0; c < ALPHABET_SIZE; c++) begin : g_lane
		tsd_ram #(
			.WIDTH(8),
			.DEPTH(ALPHABET_SIZE)
		) u_lane (
			.clk  (clk),
			.we   (req_i.wr && (req_i.column == 7'(c))),
			.addr (addr),
			.wdata(req_i.value),
			.rdata(lane_rd[c])
		);
	end

	always_comb begin
		match = '0;
		for (int c = 0; c < ALPHABET_SIZE; c++) begin
			match[c] = (lane_rd[c] == cipher_s5);
		end
	end

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_any[g] = |match_s6[g*GROUP_SIZE +: GROUP_SIZE];
			grp_idx[g] = '0;
			for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
				if (match_s6[g*GROUP_SIZE + b]) begin
					grp_idx[g] = 3'(b);
				end
			end
		end
	end

	always_comb begin
		found = 1'b0;
		col   = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (grp_any_s7[g]) begin
				found = 1'b1;
				col   = 8'(g * GROUP_SIZE) + 8'(grp_idx_s7[g]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_s5 <= 1'b0;
			look_s6 <= 1'b0;
			look_s7 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			look_s5 <= req_i.rd;
			look_s6 <= look_s5;
			look_s7 <= look_s6;
			hit_q   <= look_s7 && found;
		end
	end

	always_ff @(posedge clk) begin
		cipher_s5  <= req_i.cipher;
		match_s6   <= match;
		grp_any_s7 <= grp_any;
		grp_idx_s7 <= grp_idx;
		plain_q    <= 7'(col + tsd_pkg::CHAR_BASE);
	end

	assign hit_o        = hit_q;
	assign plain_char_o = plain_q;

endmodule

`default_nettype wire

### rtl/core/tableau_substitution_decipher.sv
// Tableau substitution decipher; a result strobe only ever follows a decipher word.
// Throughput one word per cycle while busy is low; every memory access sits at a
// fixed stage, so loads and lookups keep their order with no stall.
// Reset clears valid and control state only; busy stays high until the first edge
// after reset is released. Tableau and key contents are undefined until written.
// Depends on tsd_pkg, tsd_key_index, tsd_ram and tsd_row_match.
`default_nettype none

module tableau_substitution_decipher #(
	parameter int unsigned ALPHABET_SIZE = tsd_pkg::ALPHABET_SIZE_DEF,
	parameter int unsigned KEY_LENGTH    = tsd_pkg::KEY_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [6:0]  row,
	input  wire logic [6:0]  column,
	input  wire logic [7:0]  stored_byte,
	input  wire logic [7:0]  cipher_char,
	input  wire logic [15:0] position,
	input  wire logic [15:0] message_length,
	output logic             result_valid,
	output logic [6:0]       plain_char
);

	localparam int unsigned SUM_W  = tsd_pkg::SUM_W;
	localparam int unsigned KIDX_W = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

	logic              run_q;
	logic              accept;
	tsd_pkg::item_t    item_in;
	logic              vld_s1;
	tsd_pkg::item_t    item_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic              vld_s3;
	tsd_pkg::item_t    item_s3;
	logic [KIDX_W-1:0] kidx_s3;
	logic [KIDX_W-1:0] key_addr;
	logic [7:0]        key_rd;
	logic              vld_s4;
	tsd_pkg::item_t    item_s4;
	logic [8:0]        sel;
	logic              row_ok;
	tsd_pkg::tab_req_t req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign busy   = !run_q;
	assign accept = start && !busy;

	always_comb begin
		item_in        = '0;
		item_in.row    = row;
		item_in.column = column;
		item_in.value  = stored_byte - tsd_pkg::STORE_OFFSET;
		item_in.cipher = cipher_char;
		unique case (tsd_pkg::kind_t'(kind))
			tsd_pkg::KIND_TABLEAU: begin
				item_in.tab_load = ({1'b0, row} < 8'(ALPHABET_SIZE))
					&& ({1'b0, column} < 8'(ALPHABET_SIZE));
			end
			tsd_pkg::KIND_KEY: begin
				item_in.key_load = ({2'b0, column} < 9'(KEY_LENGTH));
			end
			tsd_pkg::KIND_DECIPHER: begin
				item_in.decipher = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_in;
		sum_s1  <= SUM_W'(position) + SUM_W'(message_length);
	end

	tsd_key_index #(
		.KEY_LENGTH(KEY_LENGTH)
	) u_key_index (
		.clk   (clk),
		.arst_n(arst_n),
		.vld_i (vld_s1),
		.item_i(item_s1),
		.sum_i (sum_s1),
		.vld_o (vld_s3),
		.item_o(item_s3),
		.kidx_o(kidx_s3)
	);

	assign key_addr = item_s3.key_load ? KIDX_W'(item_s3.column) : kidx_s3;

	tsd_ram #(
		.WIDTH(8),
		.DEPTH(KEY_LENGTH)
	) u_key_ram (
		.clk  (clk),
		.we   (vld_s3 && item_s3.key_load),
		.addr (key_addr),
		.wdata(item_s3.value),
		.rdata(key_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s4 <= item_s3;
	end

	always_comb begin
		sel        = {1'b0, key_rd} - {1'b0, tsd_pkg::CHAR_BASE};
		row_ok     = !sel[8] && (sel < 9'(ALPHABET_SIZE));
		req.wr     = vld_s4 && item_s4.tab_load;
		req.rd     = vld_s4 && item_s4.decipher && row_ok;
		req.row    = item_s4.tab_load ? item_s4.row : sel[6:0];
		req.column = item_s4.column;
		req.value  = item_s4.value;
		req.cipher = item_s4.cipher;
	end

	tsd_row_match #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_row_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_i       (req),
		.hit_o       (result_valid),
		.plain_char_o(plain_char)
	);

endmodule

`default_nettype wire

### rtl/core/tsd_checker.sv
// Port-level checks for the tableau substitution decipher, bound to the top level.
// Depends on tsd_pkg and tableau_substitution_decipher.
`default_nettype none

module tsd_checker #(
	parameter int unsigned ALPHABET_SIZE = tsd_pkg::ALPHABET_SIZE_DEF,
	parameter int unsigned LATENCY       = 8
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] kind,
	input wire logic       result_valid,
	input wire logic [6:0] plain_char
);

	// a result only ever follows a decipher word by the fixed latency
	a_result_from_decipher: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && (kind == tsd_pkg::KIND_DECIPHER), LATENCY))
		else $error("result without a decipher word at the expected latency");

	// a load or an unused kind never yields a result
	a_no_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy && (kind != tsd_pkg::KIND_DECIPHER), LATENCY) |-> !result_valid)
		else $error("result after a load word");

	// characters stay printable for the standard alphabet
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((plain_char >= 7'd33 && plain_char <= 7'd126) || ALPHABET_SIZE > 94))
		else $error("result character out of the printable range");

	// busy drops after reset is released and stays low
	a_busy_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> !busy)
		else $error("busy high after reset");

endmodule

bind tableau_substitution_decipher tsd_checker #(
	.ALPHABET_SIZE(ALPHABET_SIZE)
) u_tsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.kind        (kind),
	.result_valid(result_valid),
	.plain_char  (plain_char)
);

`default_nettype wire
